### hw/rtl/bfm_pkg.sv
// shared types and constants of the 7x7 box filter mean core
// used by bfm_front, bfm_queue, bfm_back and box_filter_7x7_mean_core
`default_nettype none
package bfm_pkg;

	localparam int ROW_W = 12;
	localparam int COL_W = 11;
	localparam int FW_W = 12;
	localparam int FH_W = 13;
	localparam int DIV_W = 16;
	localparam int SUM_W = 16;
	localparam int PIX_W = 8;
	localparam int MAX_HEIGHT = 4096;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIVISOR = 2'd2;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST = 12'd640;
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;
	localparam logic [DIV_W-1:0] DIVISOR_RST = 16'd49;

	typedef struct packed {
		logic [FW_W-1:0] frame_width;
		logic [FH_W-1:0] frame_height;
		logic [DIV_W-1:0] divisor;
	} cfg_t;

	// one window handed from the front to the divider
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [SUM_W-1:0] sum;
		logic last;
	} work_t;

endpackage
`default_nettype wire

### hw/rtl/bfm_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none
module bfm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

### hw/rtl/bfm_front.sv
// front end: raster position, line stores (read-modify-write) and column sums
// depends on bfm_pkg and bfm_ram
`default_nettype none
module bfm_front #(
	parameter int RADIUS = 3,
	parameter int MAX_WIDTH = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bfm_pkg::cfg_t     cfg,
	input  logic              push,
	input  logic [7:0]        pixel,
	output logic              full,
	input  logic              q_full,
	output logic              q_push,
	output bfm_pkg::work_t    q_item
);
	import bfm_pkg::*;

	localparam int LINES = 2 * RADIUS;
	localparam int SPAN = LINES + 1;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int SW = $clog2(LINES);
	localparam int CSW = $clog2(SPAN * 255 + 1);
	localparam int TW = $clog2(SPAN * SPAN * 255 + 1);
	localparam int MW = LINES * PIX_W;

	logic [CW-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [SW-1:0] slot_q;
	logic busy_q;

	logic [PIX_W-1:0] px_s1;
	logic [CW-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic [SW-1:0] slot_s1;
	logic deep_s1;
	logic emit_s1;
	logic last_s1;

	logic [CSW-1:0] csums_q [SPAN];
	logic [TW-1:0] total_q;

	logic [WW-1:0] eff_w;
	logic [FH_W-1:0] eff_h;
	logic col_end;
	logic row_end;
	logic at_last;
	logic acc;
	logic [MW-1:0] rd_word;
	logic [MW-1:0] wr_word;
	logic [CSW-1:0] line_sum;
	logic [CSW-1:0] csum;
	logic [TW-1:0] total_next;

	always_comb begin
		if (cfg.frame_width == '0) begin
			eff_w = WW'(1);
		end else if (32'(cfg.frame_width) > 32'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(cfg.frame_width);
		end
		if (cfg.frame_height == '0) begin
			eff_h = FH_W'(1);
		end else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT)) begin
			eff_h = FH_W'(MAX_HEIGHT);
		end else begin
			eff_h = cfg.frame_height;
		end
	end

	assign col_end = (32'(col_q) + 32'd1) >= 32'(eff_w);
	assign row_end = (32'(row_q) + 32'd1) >= 32'(eff_h);
	assign at_last = ((32'(row_q) + 32'd1) == 32'(eff_h))
		&& ((32'(col_q) + 32'd1) == 32'(eff_w));

	// one pixel in flight; the queue always has room for its window
	assign full = busy_q || q_full;
	assign acc = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			slot_q <= '0;
			busy_q <= 1'b0;
		end else begin
			busy_q <= acc;
			if (acc) begin
				if (col_end) begin
					col_q <= '0;
					if (row_end) begin
						row_q <= '0;
						slot_q <= '0;
					end else begin
						row_q <= row_q + ROW_W'(1);
						slot_q <= (slot_q == SW'(LINES - 1)) ? '0 : slot_q + SW'(1);
					end
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1 <= pixel;
			col_s1 <= col_q;
			row_s1 <= row_q;
			slot_s1 <= slot_q;
			deep_s1 <= 32'(row_q) >= 32'(LINES);
			emit_s1 <= (32'(row_q) >= 32'(LINES)) && (32'(col_q) >= 32'(LINES));
			last_s1 <= at_last;
		end
	end

	// all line stores of one column share a word; the oldest row's byte is replaced
	bfm_ram #(
		.WIDTH(MW),
		.DEPTH(MAX_WIDTH)
	) u_lines (
		.clk(clk),
		.we(busy_q),
		.waddr(col_s1),
		.wdata(wr_word),
		.re(acc),
		.raddr(col_q),
		.rdata(rd_word)
	);

	always_comb begin
		line_sum = '0;
		for (int k = 0; k < LINES; k++) begin
			line_sum = line_sum + CSW'(rd_word[k*PIX_W +: PIX_W]);
			wr_word[k*PIX_W +: PIX_W] = (slot_s1 == SW'(k)) ? px_s1
				: rd_word[k*PIX_W +: PIX_W];
		end
		csum = CSW'(px_s1) + (deep_s1 ? line_sum : '0);
	end

	// running window total: drop the oldest column, add the new one
	assign total_next = total_q - TW'(csums_q[0]) + TW'(csum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SPAN; k++) begin
				csums_q[k] <= '0;
			end
			total_q <= '0;
		end else if (busy_q) begin
			for (int k = 0; k < SPAN - 1; k++) begin
				csums_q[k] <= csums_q[k+1];
			end
			csums_q[SPAN-1] <= csum;
			total_q <= total_next;
		end
	end

	assign q_push = busy_q && emit_s1;
	assign q_item.row = row_s1 - ROW_W'(RADIUS);
	assign q_item.col = COL_W'(col_s1 - CW'(RADIUS));
	assign q_item.sum = SUM_W'(total_next);
	assign q_item.last = last_s1;
endmodule
`default_nettype wire

### hw/rtl/bfm_queue.sv
// short fifo of window totals between the front end and the divider
// depends on bfm_pkg
`default_nettype none
module bfm_queue #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  bfm_pkg::work_t wr_item,
	output logic           q_full,
	input  logic           rd,
	output bfm_pkg::work_t rd_item,
	output logic           q_empty
);
	import bfm_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	work_t slots [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0] count_q;
	logic do_wr;
	logic do_rd;

	assign q_full = count_q == (AW+1)'(DEPTH);
	assign q_empty = count_q == '0;
	assign do_wr = wr && !q_full;
	assign do_rd = rd && !q_empty;
	assign rd_item = slots[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({do_wr, do_rd})
				2'b10: count_q <= count_q + (AW+1)'(1);
				2'b01: count_q <= count_q - (AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end
endmodule
`default_nettype wire

### hw/rtl/bfm_back.sv
// back end: radix-2 divider of the window total with saturation, and output register
// depends on bfm_pkg
`default_nettype none
module bfm_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [bfm_pkg::DIV_W-1:0] divisor,
	input  logic                      q_empty,
	input  bfm_pkg::work_t            q_item,
	output logic                      q_pop,
	output logic                      empty,
	input  logic                      pop,
	output logic [bfm_pkg::ROW_W-1:0] out_row,
	output logic [bfm_pkg::COL_W-1:0] out_col,
	output logic [7:0]                mean_value,
	output logic                      frame_last
);
	import bfm_pkg::*;

	localparam int QW = 8;
	localparam int DW = DIV_W + QW;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_HOLD
	} state_t;

	state_t state_q;
	logic [SUM_W-1:0] rem_q;
	logic [DW-1:0] dsh_q;
	logic [QW-1:0] quo_q;
	logic [$clog2(QW)-1:0] step_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic last_q;
	logic out_valid_q;

	logic sat;
	logic fits;
	logic out_take;
	logic out_load;

	// quotient above 255 or a zero divisor goes straight to 255
	assign sat = (divisor == '0) || (DW'(q_item.sum) >= {divisor, QW'(0)});
	assign fits = DW'(rem_q) >= dsh_q;
	assign q_pop = (state_q == ST_IDLE) && !q_empty;
	assign out_take = pop && out_valid_q;
	assign out_load = (state_q == ST_HOLD) && (!out_valid_q || pop);
	assign empty = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rem_q <= '0;
			dsh_q <= '0;
			quo_q <= '0;
			step_q <= '0;
			row_q <= '0;
			col_q <= '0;
			last_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_row <= '0;
			out_col <= '0;
			mean_value <= '0;
			frame_last <= 1'b0;
		end else begin
			if (out_take && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						row_q <= q_item.row;
						col_q <= q_item.col;
						last_q <= q_item.last;
						rem_q <= q_item.sum;
						dsh_q <= {1'b0, divisor, (QW-1)'(0)};
						step_q <= ($clog2(QW))'(QW - 1);
						if (sat) begin
							quo_q <= '1;
							state_q <= ST_HOLD;
						end else begin
							quo_q <= '0;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (fits) begin
						rem_q <= rem_q - SUM_W'(dsh_q);
					end
					quo_q <= {quo_q[QW-2:0], fits};
					dsh_q <= dsh_q >> 1;
					if (step_q == '0) begin
						state_q <= ST_HOLD;
					end else begin
						step_q <= step_q - ($clog2(QW))'(1);
					end
				end
				ST_HOLD: begin
					if (out_load) begin
						out_row <= row_q;
						out_col <= col_q;
						mean_value <= quo_q;
						frame_last <= last_q;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
`default_nettype wire

### hw/rtl/box_filter_7x7_mean_core.sv
// Streaming 7x7 box mean filter. Pixels go in through push/full in raster order;
// each interior window leaves through empty/pop as row, column, mean and frame_last.
// Configuration (frame_width, frame_height, divisor) is written on the cfg_valid /
// cfg_ready channel, always ready; the user must write it only while the block is
// idle, which the block itself does not enforce. A pixel is taken when push is
// high and full is low. The front end first reads the line-store word of its
// column, then writes it back with the new byte and updates the column sums; full
// stays high while a pixel is in flight, as the line-store ram has a single read
// and a single write port. An interior window then passes a four-entry queue to
// the divider, which works on one window at a time: a load, eight radix-2 steps
// (skipped when the result saturates) and a fill of the output register. It takes
// the next window from the queue only after that fill. A stalled receiver holds
// the output register, then the divider, then the queue, and finally raises full.
// Reset clears the raster position, the column sums and all handshake state and
// loads 640 x 480 with divisor 49; the line store holds no reset and needs none,
// since each byte is written before its value is used.
// Depends on bfm_pkg, bfm_front, bfm_queue and bfm_back.
`default_nettype none
module box_filter_7x7_mean_core #(
	parameter int RADIUS = 3,
	parameter int MAX_WIDTH = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic [7:0]                    pixel,
	output logic                          full,
	output logic                          empty,
	input  logic                          pop,
	output logic [bfm_pkg::ROW_W-1:0]     out_row,
	output logic [bfm_pkg::COL_W-1:0]     out_col,
	output logic [7:0]                    mean_value,
	output logic                          frame_last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bfm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bfm_pkg::DIV_W-1:0]     cfg_data
);
	import bfm_pkg::*;

	localparam int QUEUE_DEPTH = 4;

	cfg_t cfg_q;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	work_t push_item;
	work_t pop_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width <= FRAME_WIDTH_RST;
			cfg_q.frame_height <= FRAME_HEIGHT_RST;
			cfg_q.divisor <= DIVISOR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FRAME_WIDTH: cfg_q.frame_width <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data[FH_W-1:0];
				REG_DIVISOR: cfg_q.divisor <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	bfm_front #(
		.RADIUS(RADIUS),
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.push(push),
		.pixel(pixel),
		.full(full),
		.q_full(q_full),
		.q_push(q_push),
		.q_item(push_item)
	);

	bfm_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(q_push),
		.wr_item(push_item),
		.q_full(q_full),
		.rd(q_pop),
		.rd_item(pop_item),
		.q_empty(q_empty)
	);

	bfm_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.divisor(cfg_q.divisor),
		.q_empty(q_empty),
		.q_item(pop_item),
		.q_pop(q_pop),
		.empty(empty),
		.pop(pop),
		.out_row(out_row),
		.out_col(out_col),
		.mean_value(mean_value),
		.frame_last(frame_last)
	);
endmodule
`default_nettype wire
